>>> rtl/kmeq_pkg.sv
// shared constants, types and event codes of the key and mouse event qualifier
`timescale 1ns / 1ps

package kmeq_pkg;

    // size of the per-key state and width of the tick arithmetic
    localparam int KEY_COUNT = 256;
    localparam int TICK_BITS = 32;

    // fixed field widths
    localparam int CODE_W = 8;
    localparam int POS_W  = 16;
    localparam int CFG_W  = 16;
    localparam int ADDR_W = $clog2(KEY_COUNT);

    // configuration reset values
    localparam logic [CFG_W-1:0] DBL_WINDOW_RESET   = 16'd500;
    localparam logic [CFG_W-1:0] RPT_INTERVAL_RESET = 16'd75;

    // event codes on the result channel
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_KEY_DOWN   = 3'd1,
        EV_KEY_REPEAT = 3'd2,
        EV_KEY_UP     = 3'd3,
        EV_LEFT_DOWN  = 3'd4,
        EV_LEFT_UP    = 3'd5,
        EV_RIGHT_DOWN = 3'd6,
        EV_RIGHT_UP   = 3'd7
    } t_event_kind;

    // configuration register indexes
    typedef enum logic {
        CFG_DBL_WINDOW   = 1'b0,
        CFG_RPT_INTERVAL = 1'b1
    } t_cfg_index;

    // special key codes
    localparam logic [CODE_W-1:0] CODE_LEFT  = 8'd1;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 8'd2;

    // one entry of the per-key memory
    typedef struct packed {
        logic                 level;
        logic [TICK_BITS-1:0] deadline;
    } t_key_entry;

    localparam int ENTRY_W = $bits(t_key_entry);

endpackage

>>> rtl/kmeq_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module kmeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/key_mouse_event_qualifier.sv
// top level of the key and mouse event qualifier
`timescale 1ns / 1ps

// Usage
// Input channel (i_in_valid / o_in_ready) carries one sampled key or button
// level with its tick time and cursor position. Result channel (o_out_valid /
// i_out_ready) returns exactly one result per request: an event kind, the
// double-click flag, the key code and the cursor position, all zero when the
// request causes no event. Configuration channel (i_cfg_valid / o_cfg_ready)
// writes the double-click window or the repeat interval; it is always ready.
// The user must use it only while no request is in flight; the block itself
// does not enforce this. Throughput: one request per cycle while the
// receiver does not stall. The per-key level and repeat deadline live in a
// ram with registered read data; the modify stage takes the read data,
// modifies and writes the entry back, and a request to the key written in
// the same cycle takes the written entry through a bypass.
// Reset clears both configuration registers to their defaults, the press
// times and positions, and a valid bit per key so that unwritten keys read as
// released with a zero deadline. When the receiver stalls, the result holds
// in the output register while one more request is taken into the
// read stage; the input then stalls too.

module key_mouse_event_qualifier (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [31:0]                           i_tick_time,
    input  logic [kmeq_pkg::CODE_W-1:0]           i_key_code,
    input  logic                                  i_pressed,
    input  logic signed [kmeq_pkg::POS_W-1:0]     i_cursor_x,
    input  logic signed [kmeq_pkg::POS_W-1:0]     i_cursor_y,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [2:0]                            o_event_kind,
    output logic                                  o_double_click,
    output logic [kmeq_pkg::CODE_W-1:0]           o_event_code,
    output logic signed [kmeq_pkg::POS_W-1:0]     o_event_x,
    output logic signed [kmeq_pkg::POS_W-1:0]     o_event_y,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic                                  i_cfg_index,
    input  logic [kmeq_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int TB = kmeq_pkg::TICK_BITS;
    localparam int AW = kmeq_pkg::ADDR_W;
    localparam logic [kmeq_pkg::CODE_W:0] KEY_LIMIT = (kmeq_pkg::CODE_W + 1)'(kmeq_pkg::KEY_COUNT);

    // configuration registers
    logic [kmeq_pkg::CFG_W-1:0] r_dbl_window;
    logic [kmeq_pkg::CFG_W-1:0] r_rpt_interval;

    // button press history
    logic [TB-1:0]              r_left_time;
    logic [TB-1:0]              r_right_time;
    logic [2*kmeq_pkg::POS_W-1:0] r_left_pos;
    logic [2*kmeq_pkg::POS_W-1:0] r_right_pos;

    // per-key valid bits
    logic [kmeq_pkg::KEY_COUNT-1:0] r_key_vld;

    // modify stage
    logic                         r_s1_valid;
    logic [TB-1:0]                r_s1_tick;
    logic [kmeq_pkg::CODE_W-1:0]  r_s1_code;
    logic                         r_s1_level;
    logic [kmeq_pkg::POS_W-1:0]   r_s1_x;
    logic [kmeq_pkg::POS_W-1:0]   r_s1_y;
    logic                         r_s1_in_range;
    logic                         r_s1_key_vld;
    logic                         r_s1_fwd_hit;
    kmeq_pkg::t_key_entry         r_s1_fwd_data;

    // output register
    logic                         r_out_valid;
    kmeq_pkg::t_event_kind        r_out_kind;
    logic                         r_out_dbl;
    logic [kmeq_pkg::CODE_W-1:0]  r_out_code;
    logic [kmeq_pkg::POS_W-1:0]   r_out_x;
    logic [kmeq_pkg::POS_W-1:0]   r_out_y;

    logic                         w_in_accept;
    logic                         w_s1_advance;
    logic                         w_wr_en;
    logic [AW-1:0]                w_wr_addr;
    logic [AW-1:0]                w_rd_addr;
    logic [kmeq_pkg::ENTRY_W-1:0] w_rd_data;
    kmeq_pkg::t_key_entry         w_prev;
    kmeq_pkg::t_key_entry         w_wr_entry;
    logic [TB-1:0]                w_dl_diff;
    logic [TB-1:0]                w_next_dl;
    logic [TB-1:0]                w_left_diff;
    logic [TB-1:0]                w_right_diff;
    logic [2*kmeq_pkg::POS_W-1:0] w_pos;
    logic                         w_past;
    logic                         w_dbl_left;
    logic                         w_dbl_right;
    logic                         w_is_left;
    logic                         w_is_right;
    logic                         w_is_key;
    logic                         w_dl_upd;
    logic                         w_left_upd;
    logic                         w_right_upd;
    logic                         n_dbl;
    kmeq_pkg::t_event_kind        n_kind;

    // handshakes
    assign w_s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready   = !r_s1_valid || w_s1_advance;
    assign w_in_accept  = i_in_valid && o_in_ready;
    assign o_cfg_ready  = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbl_window   <= kmeq_pkg::DBL_WINDOW_RESET;
            r_rpt_interval <= kmeq_pkg::RPT_INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (kmeq_pkg::t_cfg_index'(i_cfg_index))
                kmeq_pkg::CFG_DBL_WINDOW:   r_dbl_window   <= i_cfg_data;
                kmeq_pkg::CFG_RPT_INTERVAL: r_rpt_interval <= i_cfg_data;
            endcase
        end
    end

    // per-key memory
    assign w_rd_addr = i_key_code[AW-1:0];
    assign w_wr_addr = r_s1_code[AW-1:0];
    assign w_wr_en   = w_s1_advance && r_s1_in_range;

    kmeq_ram #(
        .WIDTH (kmeq_pkg::ENTRY_W),
        .DEPTH (kmeq_pkg::KEY_COUNT)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_in_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // valid bits, set on first write of a key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
        end else if (w_wr_en) begin
            r_key_vld[w_wr_addr] <= 1'b1;
        end
    end

    // read stage: capture request, valid bit and bypass of the write this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_tick     <= TB'(i_tick_time);
            r_s1_code     <= i_key_code;
            r_s1_level    <= i_pressed;
            r_s1_x        <= i_cursor_x;
            r_s1_y        <= i_cursor_y;
            r_s1_in_range <= {1'b0, i_key_code} < KEY_LIMIT;
            r_s1_key_vld  <= r_key_vld[w_rd_addr];
            r_s1_fwd_hit  <= w_wr_en && (w_wr_addr == w_rd_addr);
            r_s1_fwd_data <= w_wr_entry;
        end
    end

    // previous entry: bypass, then ram, then reset value
    always_comb begin
        if (r_s1_fwd_hit) begin
            w_prev = r_s1_fwd_data;
        end else if (r_s1_key_vld) begin
            w_prev = kmeq_pkg::t_key_entry'(w_rd_data);
        end else begin
            w_prev = '0;
        end
    end

    // tick arithmetic
    assign w_pos        = {r_s1_y, r_s1_x};
    assign w_dl_diff    = r_s1_tick - w_prev.deadline;
    assign w_past       = (w_dl_diff != '0) && !w_dl_diff[TB-1];
    assign w_next_dl    = r_s1_tick + TB'(r_rpt_interval);
    assign w_left_diff  = r_s1_tick - r_left_time;
    assign w_right_diff = r_s1_tick - r_right_time;
    assign w_dbl_left   = (w_left_diff < TB'(r_dbl_window)) && (w_pos == r_left_pos);
    assign w_dbl_right  = (w_right_diff < TB'(r_dbl_window)) && (w_pos == r_right_pos);

    assign w_is_left  = r_s1_code == kmeq_pkg::CODE_LEFT;
    assign w_is_right = r_s1_code == kmeq_pkg::CODE_RIGHT;
    assign w_is_key   = r_s1_code > kmeq_pkg::CODE_RIGHT;

    // event decode
    always_comb begin
        n_kind      = kmeq_pkg::EV_NONE;
        n_dbl       = 1'b0;
        w_dl_upd    = 1'b0;
        w_left_upd  = 1'b0;
        w_right_upd = 1'b0;
        if (r_s1_in_range) begin
            if (r_s1_level && !w_prev.level) begin
                if (w_is_left) begin
                    n_kind     = kmeq_pkg::EV_LEFT_DOWN;
                    n_dbl      = w_dbl_left;
                    w_left_upd = 1'b1;
                end else if (w_is_right) begin
                    n_kind      = kmeq_pkg::EV_RIGHT_DOWN;
                    n_dbl       = w_dbl_right;
                    w_right_upd = 1'b1;
                end else begin
                    n_kind   = kmeq_pkg::EV_KEY_DOWN;
                    w_dl_upd = 1'b1;
                end
            end else if (r_s1_level && w_prev.level) begin
                if (w_is_key && w_past) begin
                    n_kind   = kmeq_pkg::EV_KEY_REPEAT;
                    w_dl_upd = 1'b1;
                end
            end else if (!r_s1_level && w_prev.level) begin
                if (w_is_left) begin
                    n_kind = kmeq_pkg::EV_LEFT_UP;
                end else if (w_is_right) begin
                    n_kind = kmeq_pkg::EV_RIGHT_UP;
                end else if (w_is_key) begin
                    n_kind = kmeq_pkg::EV_KEY_UP;
                end
            end
        end
    end

    // write-back entry
    assign w_wr_entry.level    = r_s1_level;
    assign w_wr_entry.deadline = w_dl_upd ? w_next_dl : w_prev.deadline;

    // button press history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_time  <= '0;
            r_right_time <= '0;
            r_left_pos   <= '0;
            r_right_pos  <= '0;
        end else if (w_s1_advance) begin
            if (w_left_upd) begin
                r_left_time <= r_s1_tick;
                r_left_pos  <= w_pos;
            end
            if (w_right_upd) begin
                r_right_time <= r_s1_tick;
                r_right_pos  <= w_pos;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_advance) begin
            r_out_kind <= n_kind;
            if (n_kind == kmeq_pkg::EV_NONE) begin
                r_out_dbl  <= 1'b0;
                r_out_code <= '0;
                r_out_x    <= '0;
                r_out_y    <= '0;
            end else begin
                r_out_dbl  <= n_dbl;
                r_out_code <= r_s1_code;
                r_out_x    <= r_s1_x;
                r_out_y    <= r_s1_y;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_double_click = r_out_dbl;
    assign o_event_code   = r_out_code;
    assign o_event_x      = r_out_x;
    assign o_event_y      = r_out_y;

endmodule

>>> rtl/kmeq_checker.sv
// port-level checks of the key and mouse event qualifier, bound to the top level
`timescale 1ns / 1ps

module kmeq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [2:0]                  o_event_kind,
    input logic                        o_double_click,
    input logic [kmeq_pkg::CODE_W-1:0] o_event_code,
    input logic [kmeq_pkg::POS_W-1:0]  o_event_x,
    input logic [kmeq_pkg::POS_W-1:0]  o_event_y
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result keeps its kind, code and double-click flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_event_kind) && $stable(o_event_code)
            && $stable(o_double_click))
        else $error("stalled result changed");

    // empty event carries all-zero fields
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == kmeq_pkg::EV_NONE) |->
            !o_double_click && (o_event_code == '0) && (o_event_x == '0)
            && (o_event_y == '0))
        else $error("empty event with nonzero fields");

    // double click only on a button down
    a_dbl_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_double_click |->
            (o_event_kind == kmeq_pkg::EV_LEFT_DOWN)
            || (o_event_kind == kmeq_pkg::EV_RIGHT_DOWN))
        else $error("double click on a non-press event");

    // left button events carry the left button code
    a_left_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_event_kind == kmeq_pkg::EV_LEFT_DOWN)
            || (o_event_kind == kmeq_pkg::EV_LEFT_UP)) |->
            o_event_code == kmeq_pkg::CODE_LEFT)
        else $error("left button event with wrong code");

endmodule

bind key_mouse_event_qualifier kmeq_checker u_kmeq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_kind   (o_event_kind),
    .o_double_click (o_double_click),
    .o_event_code   (o_event_code),
    .o_event_x      (o_event_x),
    .o_event_y      (o_event_y)
);
